// File: design/xmcrx_pkg.sv
// shared constants, types and the crc byte update for the xmodem crc receiver
package xmcrx_pkg;

	localparam int PAGE_BYTES_DEF = 1024;
	localparam int PAYLOAD_BYTES  = 128;
	localparam int FRAME_BYTES    = 133;

	localparam logic [15:0] CRC_GEN  = 16'h1021;
	localparam logic [15:0] CRC_SEED = 16'h0000;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	localparam logic [7:0] SOH_CODE  = 8'h01;
	localparam logic [7:0] EOT_CODE  = 8'h04;
	localparam logic [7:0] PAY_FIRST = 8'd3;
	localparam logic [7:0] PAY_LAST  = 8'(3 + PAYLOAD_BYTES - 1);
	localparam logic [7:0] CHK_HI    = 8'(3 + PAYLOAD_BYTES);
	localparam logic [7:0] CHK_LO    = 8'(3 + PAYLOAD_BYTES + 1);
	localparam logic [7:0] LAST_POS  = 8'(FRAME_BYTES - 1);
	localparam logic [7:0] POS_MAX   = 8'hff;

	typedef enum logic [1:0] {
		RESP_NONE = 2'd0,
		RESP_ACK  = 2'd1,
		RESP_NAK  = 2'd2
	} resp_t;

	// msb-first crc-16 update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = (c << 1) ^ CRC_GEN;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// File: design/xmcrx_ram.sv
// generic single write port ram with registered read
module xmcrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/xmodem_crc_packet_receiver.sv
// xmodem crc-16 packet receiver with page store, top level
//
// input beats carry mode, rx_byte, frame_end and read_index. in mode 0 each
// beat is one received byte; the beat flagged frame_end closes the frame and
// its result carries the ack/nak reply, page_ready with page_number and
// page_bytes, and transfer_done for an eot frame. other beats give a result
// with response none. in mode 1 a beat reads one page store byte, returned
// in store_byte of its result. every input beat gives exactly one result beat.
// each beat passes through one input register, then the frame logic and crc
// update into the result register, with the page store read registered
// alongside. one beat is taken every cycle; the input side stalls only while
// the result register is full and stalled.
// reset clears the frame state, crc, packet count and both pipeline valids;
// the page store is not cleared and holds garbage until written.
module xmodem_crc_packet_receiver #(
	parameter int PAGE_BYTES = xmcrx_pkg::PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic [9:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  response,
	output logic        page_ready,
	output logic [12:0] page_number,
	output logic [10:0] page_bytes,
	output logic        transfer_done,
	output logic [15:0] packets_received,
	output logic [7:0]  store_byte
);

	localparam int PPP    = PAGE_BYTES / xmcrx_pkg::PAYLOAD_BYTES;
	localparam int SLOT_W = (PPP > 1) ? $clog2(PPP) : 1;
	localparam int ADDR_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(PPP - 1);
	localparam logic [12:0]       IDX_LIM    = 13'(PAGE_BYTES);
	localparam logic [12:0]       FULL_BYTES = 13'(PPP * xmcrx_pkg::PAYLOAD_BYTES);

	// input register
	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;
	logic        fend_s1;
	logic [9:0]  ridx_s1;

	// frame and transfer state
	logic [7:0]        pos_q;
	logic [7:0]        first_byte_q;
	logic [15:0]       crc_q;
	logic [15:0]       rx_crc_q;
	logic [15:0]       count_q;
	logic [SLOT_W-1:0] slot_q;
	logic [12:0]       page_q;

	// result register
	logic        rd_valid_s2;
	logic [7:0]  ram_rdata;

	logic s2_free;
	logic fire;
	logic load;

	// next state and result
	logic [7:0]        pos_d;
	logic [7:0]        first_byte_d;
	logic [15:0]       crc_d;
	logic [15:0]       rx_crc_d;
	logic [15:0]       count_d;
	logic [SLOT_W-1:0] slot_d;
	logic [12:0]       page_d;
	xmcrx_pkg::resp_t  resp_d;
	logic              ready_d;
	logic [12:0]       pnum_d;
	logic [12:0]       pbytes_d;
	logic              done_d;
	logic [15:0]       pkts_d;
	logic              rd_hit;

	logic [7:0]  b0;
	logic [7:0]  pos_m3;
	logic [12:0] wr_off;
	logic [12:0] rd_off;
	logic        wr_en;
	logic        is_payload;
	logic [15:0] count_inc;
	logic        wrap;
	logic        roll;

	assign s2_free  = !out_valid || !out_stall;
	assign fire     = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
			fend_s1 <= frame_end;
			ridx_s1 <= read_index;
		end
	end

	assign b0         = (pos_q == 8'd0) ? byte_s1 : first_byte_q;
	assign pos_m3     = pos_q - xmcrx_pkg::PAY_FIRST;
	assign wr_off     = (13'(slot_q) << 7) | {6'd0, pos_m3[6:0]};
	assign rd_off     = {3'd0, ridx_s1};
	assign is_payload = (pos_q >= xmcrx_pkg::PAY_FIRST) && (pos_q <= xmcrx_pkg::PAY_LAST);
	assign wr_en      = fire && !mode_s1 && is_payload && (b0 == xmcrx_pkg::SOH_CODE);
	assign rd_hit     = mode_s1 && (rd_off < IDX_LIM);
	assign count_inc  = count_q + 16'd1;
	assign wrap       = (count_inc == 16'd0);
	assign roll       = (slot_q == SLOT_LAST);

	always_comb begin
		pos_d        = pos_q;
		first_byte_d = first_byte_q;
		crc_d        = crc_q;
		rx_crc_d     = rx_crc_q;
		count_d      = count_q;
		slot_d       = slot_q;
		page_d       = page_q;
		resp_d       = xmcrx_pkg::RESP_NONE;
		ready_d      = 1'b0;
		pnum_d       = 13'd0;
		pbytes_d     = 13'd0;
		done_d       = 1'b0;
		pkts_d       = count_q;
		if (!mode_s1) begin
			if (pos_q == 8'd0) begin
				first_byte_d = byte_s1;
			end
			if (is_payload) begin
				crc_d = xmcrx_pkg::crc_byte(crc_q, byte_s1);
			end else if (pos_q == xmcrx_pkg::CHK_HI) begin
				rx_crc_d = {byte_s1, 8'h00};
			end else if (pos_q == xmcrx_pkg::CHK_LO) begin
				rx_crc_d = {rx_crc_q[15:8], byte_s1};
			end
			if (fend_s1) begin
				if (pos_q == xmcrx_pkg::LAST_POS && b0 == xmcrx_pkg::SOH_CODE) begin
					if (crc_q == rx_crc_d) begin
						resp_d  = xmcrx_pkg::RESP_ACK;
						count_d = count_inc;
						pkts_d  = count_inc;
						if (wrap || roll) begin
							slot_d   = '0;
							page_d   = wrap ? 13'd0 : page_q + 13'd1;
							ready_d  = 1'b1;
							pnum_d   = page_d - 13'd1;
							pbytes_d = FULL_BYTES;
						end else begin
							slot_d = slot_q + SLOT_W'(1);
						end
					end else begin
						resp_d = xmcrx_pkg::RESP_NAK;
					end
				end else if (pos_q == 8'd0 && byte_s1 == xmcrx_pkg::EOT_CODE) begin
					resp_d = xmcrx_pkg::RESP_ACK;
					if (slot_q != '0) begin
						ready_d  = 1'b1;
						pnum_d   = page_q;
						pbytes_d = 13'(slot_q) << 7;
					end
					done_d  = 1'b1;
					count_d = 16'd0;
					slot_d  = '0;
					page_d  = 13'd0;
				end
				pos_d    = 8'd0;
				crc_d    = xmcrx_pkg::CRC_SEED;
				rx_crc_d = 16'h0000;
			end else if (pos_q != xmcrx_pkg::POS_MAX) begin
				pos_d = pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 8'd0;
			first_byte_q <= 8'd0;
			crc_q        <= xmcrx_pkg::CRC_SEED;
			rx_crc_q     <= 16'h0000;
			count_q      <= 16'd0;
			slot_q       <= '0;
			page_q       <= 13'd0;
			out_valid    <= 1'b0;
		end else begin
			if (fire) begin
				pos_q        <= pos_d;
				first_byte_q <= first_byte_d;
				crc_q        <= crc_d;
				rx_crc_q     <= rx_crc_d;
				count_q      <= count_d;
				slot_q       <= slot_d;
				page_q       <= page_d;
				out_valid    <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			response         <= resp_d;
			page_ready       <= ready_d;
			page_number      <= pnum_d;
			page_bytes       <= pbytes_d[10:0];
			transfer_done    <= done_d;
			packets_received <= pkts_d;
			rd_valid_s2      <= rd_hit;
		end
	end

	xmcrx_ram #(
		.WIDTH (8),
		.DEPTH (PAGE_BYTES),
		.AW    (ADDR_W)
	) u_page_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_off[ADDR_W-1:0]),
		.wr_data (byte_s1),
		.rd_en   (fire && rd_hit),
		.rd_addr (rd_off[ADDR_W-1:0]),
		.rd_data (ram_rdata)
	);

	assign store_byte = rd_valid_s2 ? ram_rdata : 8'd0;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("input stalled without a full stalled result");

	a_ready_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && page_ready) |-> (response == xmcrx_pkg::RESP_ACK))
		else $error("page ready without ack");

	a_idle_page_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !page_ready) |-> (page_number == 13'd0 && page_bytes == 11'd0))
		else $error("page fields set without page ready");

	a_done_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done_d) |=> (count_q == 16'd0 && slot_q == '0))
		else $error("count not cleared after end of transfer");

endmodule

// File: tb/xmodem_crc_packet_receiver_checker.sv
// reply predictor and scoreboard for the xmodem crc packet receiver
`timescale 1ns / 1ps

module xmodem_crc_packet_receiver_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 mode,
	input  logic [7:0]                           rx_byte,
	input  logic                                 frame_end,
	input  logic [9:0]                           read_index,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [1:0]                           response,
	input  logic                                 page_ready,
	input  logic [12:0]                          page_number,
	input  logic [10:0]                          page_bytes,
	input  logic                                 transfer_done,
	input  logic [15:0]                          packets_received,
	input  logic [7:0]                           store_byte,
	output int                                   mismatches,
	output int                                   replies_owed,
	output int                                   replies_checked,
	output int                                   pages_flushed,
	output logic [xmcrx_pkg::PAGE_BYTES_DEF-1:0] store_filled
);

	localparam int SLOTS = xmcrx_pkg::PAGE_BYTES_DEF / xmcrx_pkg::PAYLOAD_BYTES;

	typedef struct packed {
		xmcrx_pkg::resp_t response;
		logic             page_ready;
		logic [12:0]      page_number;
		logic [10:0]      page_bytes;
		logic             transfer_done;
		logic [15:0]      packets;
		logic [7:0]       store_byte;
	} rx_reply_t;

	logic [7:0]  frame_pos;
	logic [7:0]  frame_lead;
	logic [15:0] run_crc;
	logic [15:0] got_crc;
	logic [15:0] good_cnt;
	logic [7:0]  page_mem [xmcrx_pkg::PAGE_BYTES_DEF];
	rx_reply_t   owed_replies [$];
	rx_reply_t   want;

	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? xmcrx_pkg::CRC_GEN : 16'h0000);
		end
		return c;
	endfunction

	function automatic rx_reply_t next_reply(input logic m, input logic [7:0] b, input logic fe,
			input logic [9:0] idx);
		rx_reply_t r;
		logic [7:0] lead;
		int         spot;
		int         left;
		r = '0;
		r.response = xmcrx_pkg::RESP_NONE;
		if (m) begin
			r.store_byte = page_mem[idx];
			r.packets = good_cnt;
		end else begin
			lead = (frame_pos == 8'd0) ? b : frame_lead;
			if (frame_pos == 8'd0) frame_lead = b;
			if (frame_pos >= xmcrx_pkg::PAY_FIRST && frame_pos <= xmcrx_pkg::PAY_LAST) begin
				run_crc = crc_step(run_crc, b);
				if (lead == xmcrx_pkg::SOH_CODE) begin
					spot = (int'(good_cnt) % SLOTS) * xmcrx_pkg::PAYLOAD_BYTES
						+ int'(frame_pos - xmcrx_pkg::PAY_FIRST);
					page_mem[spot] = b;
					store_filled[spot] = 1'b1;
				end
			end else if (frame_pos == xmcrx_pkg::CHK_HI) begin
				got_crc = {b, 8'h00};
			end else if (frame_pos == xmcrx_pkg::CHK_LO) begin
				got_crc[7:0] = b;
			end
			r.packets = good_cnt;
			if (fe) begin
				if (frame_pos == xmcrx_pkg::LAST_POS && lead == xmcrx_pkg::SOH_CODE) begin
					if (run_crc == got_crc) begin
						good_cnt = good_cnt + 16'd1;
						r.response = xmcrx_pkg::RESP_ACK;
						if (int'(good_cnt) % SLOTS == 0) begin
							r.page_ready = 1'b1;
							r.page_number = 13'(int'(good_cnt) / SLOTS - 1);
							r.page_bytes = 11'(xmcrx_pkg::PAGE_BYTES_DEF);
						end
					end else begin
						r.response = xmcrx_pkg::RESP_NAK;
					end
					r.packets = good_cnt;
				end else if (frame_pos == 8'd0 && b == xmcrx_pkg::EOT_CODE) begin
					left = int'(good_cnt) % SLOTS;
					r.response = xmcrx_pkg::RESP_ACK;
					if (left != 0) begin
						r.page_ready = 1'b1;
						r.page_number = 13'(int'(good_cnt) / SLOTS);
						r.page_bytes = 11'(left * xmcrx_pkg::PAYLOAD_BYTES);
					end
					r.transfer_done = 1'b1;
					r.packets = good_cnt;
					good_cnt = 16'd0;
				end
				frame_pos = 8'd0;
				run_crc = xmcrx_pkg::CRC_SEED;
				got_crc = 16'h0000;
			end else if (frame_pos != xmcrx_pkg::POS_MAX) begin
				frame_pos = frame_pos + 8'd1;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v, input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s at reply %0d: expected %0d, got %0d",
					name, replies_checked, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos = 8'd0;
			frame_lead = 8'd0;
			run_crc = xmcrx_pkg::CRC_SEED;
			got_crc = 16'h0000;
			good_cnt = 16'd0;
			store_filled = '0;
			owed_replies.delete();
			replies_owed <= 0;
		end else begin
			if (in_valid && !in_stall)
				owed_replies.push_back(next_reply(mode, rx_byte, frame_end, read_index));
			if (out_valid && !out_stall) begin
				if (owed_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply beat with nothing expected, response %0d", response);
				end else begin
					want = owed_replies.pop_front();
					check_field("response", 16'(want.response), 16'(response));
					check_field("page_ready", 16'(want.page_ready), 16'(page_ready));
					check_field("page_number", 16'(want.page_number), 16'(page_number));
					check_field("page_bytes", 16'(want.page_bytes), 16'(page_bytes));
					check_field("transfer_done", 16'(want.transfer_done), 16'(transfer_done));
					check_field("packets_received", want.packets, packets_received);
					check_field("store_byte", 16'(want.store_byte), 16'(store_byte));
					if (want.page_ready) pages_flushed++;
					replies_checked++;
				end
			end
			replies_owed <= owed_replies.size();
		end
	end

endmodule

// File: tb/xmodem_crc_packet_receiver_test.sv
// stimulus and verdict for the xmodem crc packet receiver
`timescale 1ns / 1ps

module xmodem_crc_packet_receiver_test;

	typedef logic [7:0] octet_q_t [$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic [9:0]  read_index = 10'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  response;
	logic        page_ready;
	logic [12:0] page_number;
	logic [10:0] page_bytes;
	logic        transfer_done;
	logic [15:0] packets_received;
	logic [7:0]  store_byte;

	int                                   mismatches;
	int                                   replies_owed;
	int                                   replies_checked;
	int                                   pages_flushed;
	logic [xmcrx_pkg::PAGE_BYTES_DEF-1:0] store_filled;

	int         beats_sent = 0;
	int         packets_built = 0;
	int         hold_left = 0;
	int         hold_draw;
	bit         calm = 1'b0;
	logic [7:0] blk_no = 8'd1;

	always #2 clk = ~clk;

	xmodem_crc_packet_receiver u_top (.*);

	xmodem_crc_packet_receiver_checker u_checker (.*);

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else if (out_valid && !out_stall) begin
			hold_draw = calm ? 0 : $urandom_range(0, 16);
			hold_left <= hold_draw;
			out_stall <= (hold_draw != 0);
		end
	end

	task automatic send_beat(input logic m, input logic [7:0] b, input logic fe,
			input logic [9:0] idx);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		rx_byte <= b;
		frame_end <= fe;
		read_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		if (beats_sent % 150 == 0) calm = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic [9:0] pick_index();
		logic [9:0] k;
		k = 10'($urandom);
		for (int t = 0; t < xmcrx_pkg::PAGE_BYTES_DEF; t++) begin
			if (store_filled[k]) return k;
			k++;
		end
		return k;
	endfunction

	task automatic send_read();
		send_beat(1'b1, 8'($urandom), 1'($urandom), pick_index());
	endtask

	task automatic send_frame(input octet_q_t f);
		for (int i = 0; i < f.size(); i++) begin
			if (store_filled != '0 && $urandom_range(0, 49) == 0) send_read();
			send_beat(1'b0, f[i], i == f.size() - 1, 10'($urandom));
		end
	endtask

	task automatic send_packet(input bit intact);
		octet_q_t    f;
		logic [15:0] c;
		logic [7:0]  d;
		int          spot;
		c = xmcrx_pkg::CRC_SEED;
		f = {xmcrx_pkg::SOH_CODE, blk_no, ~blk_no};
		for (int i = 0; i < xmcrx_pkg::PAYLOAD_BYTES; i++) begin
			d = 8'($urandom);
			f.push_back(d);
			c = xmcrx_pkg::crc_byte(c, d);
		end
		f.push_back(c[15:8]);
		f.push_back(c[7:0]);
		if (intact) begin
			blk_no++;
			packets_built++;
		end else begin
			spot = $urandom_range(3, xmcrx_pkg::FRAME_BYTES - 1);
			f[spot] = f[spot] ^ 8'(1 << $urandom_range(0, 7));
		end
		send_frame(f);
	endtask

	task automatic send_odd_frame(input int len, input logic [7:0] lead);
		octet_q_t f;
		f = {lead};
		repeat (len - 1) f.push_back(8'($urandom));
		send_frame(f);
	endtask

	initial begin
		int pick;
		int settle;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// eot with nothing pending, stray single bytes, eot that is not alone
		send_frame({xmcrx_pkg::EOT_CODE});
		send_frame({8'hff});
		send_frame({8'h00});
		send_frame({xmcrx_pkg::EOT_CODE, xmcrx_pkg::EOT_CODE});
		send_frame({xmcrx_pkg::EOT_CODE, 8'hff});
		send_frame({xmcrx_pkg::SOH_CODE});
		// short soh frame leaves its payload bytes in the open slot
		send_frame({xmcrx_pkg::SOH_CODE, 8'h7f, 8'h80, 8'haa, 8'h55});
		send_beat(1'b1, 8'hff, 1'b1, 10'd0);
		send_beat(1'b1, 8'h00, 1'b0, 10'd1);

		// overlong frame, position saturates
		send_odd_frame($urandom_range(256, 300), xmcrx_pkg::SOH_CODE);
		while (beats_sent < 1750) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_packet(1'b1);
			end else if (pick < 65) begin
				send_packet(1'b0);
			end else if (pick < 69) begin
				send_frame({xmcrx_pkg::EOT_CODE});
			end else if (pick < 79) begin
				if (store_filled != '0) repeat ($urandom_range(1, 8)) send_read();
			end else if (pick < 89) begin
				case ($urandom_range(0, 2))
					0: send_odd_frame($urandom_range(1, 6), xmcrx_pkg::SOH_CODE);
					1: send_odd_frame($urandom_range(1, 6), xmcrx_pkg::EOT_CODE);
					default: send_odd_frame($urandom_range(1, 6), 8'($urandom));
				endcase
			end else if (pick < 97) begin
				send_odd_frame($urandom_range(1, 140),
					($urandom_range(0, 4) == 0) ? 8'($urandom) : xmcrx_pkg::SOH_CODE);
			end else begin
				send_odd_frame($urandom_range(256, 300), xmcrx_pkg::SOH_CODE);
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		for (settle = 0; settle < 5000 && replies_owed != 0; settle++) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d input beats and %0d good packets, %0d replies checked",
			beats_sent, packets_built, replies_checked);
		$display("%0d page flushes seen, %0d mismatches, %0d replies still owed",
			pages_flushed, mismatches, replies_owed);
		if (mismatches == 0 && replies_owed == 0) begin
			$display("xmodem_crc_packet_receiver regression: pass");
		end else begin
			$display("xmodem_crc_packet_receiver regression: fail");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout");
		$display("xmodem_crc_packet_receiver regression: fail");
		$finish;
	end

endmodule
